[hw/rtl/lft_pkg.sv]
// Shared types, constants and helper functions of the line field tokenizer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lft_pkg;

	// Number of bytes in each character set register.
	localparam int SET_BYTES = 8;
	// Depth of the queue between front and back.
	localparam int QDEPTH = 4;
	// Configuration address width: five 64-bit registers at 8-byte spacing.
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	// Character constants.
	localparam logic [7:0] CHAR_NUL    = 8'h00;
	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_DQUOTE = 8'h22;
	localparam logic [7:0] CHAR_BSLASH = 8'h5C;

	// Register reset values.
	localparam logic [63:0] SEP_RESET   = 64'h0000_000C_0D0B_0920;
	localparam logic [63:0] DELIM_RESET = 64'h0;
	localparam logic [63:0] EOL_RESET   = 64'h0000_0000_0000_0D0A;
	localparam logic [63:0] QUOTE_RESET = 64'h0;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_FIELD_END,
		KIND_LINE_END,
		KIND_INPUT_END
	} kind_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       input_end;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  field_byte;
		logic [15:0] line_number;
		logic        last_result;
	} result_t;

	// One queue entry holds all results of one input word.
	typedef struct packed {
		logic    two;
		result_t rec0;
		result_t rec1;
	} entry_t;

	typedef struct packed {
		logic [63:0] separator_set;
		logic [63:0] delimiter_set;
		logic [63:0] line_end_set;
		logic [63:0] quote_set;
		logic        keep_quotes;
	} cfg_t;

	// True when c is a nonzero byte found in the packed set.
	function automatic logic is_member(logic [63:0] set, logic [7:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < SET_BYTES; i++) begin
			if (set[8*i +: 8] == c) begin
				hit = 1'b1;
			end
		end
		return hit && (c != CHAR_NUL);
	endfunction

	function automatic result_t make_result(kind_t k, logic [7:0] b, logic [15:0] ln);
		result_t r;
		r.kind        = k;
		r.field_byte  = b;
		r.line_number = ln;
		r.last_result = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/lft_regs.sv]
// Configuration registers of the line field tokenizer behind an APB-style port.
// Depends on lft_pkg.
`default_nettype none

module lft_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [lft_pkg::ADDR_W-1:0] paddr,
	input  wire logic [lft_pkg::DATA_W-1:0] pwdata,
	output logic      [lft_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output lft_pkg::cfg_t                   cfg
);
	import lft_pkg::*;

	localparam logic [2:0] REG_SEP   = 3'd0;
	localparam logic [2:0] REG_DELIM = 3'd1;
	localparam logic [2:0] REG_EOL   = 3'd2;
	localparam logic [2:0] REG_QUOTE = 3'd3;
	localparam logic [2:0] REG_KEEP  = 3'd4;

	cfg_t       cfg_q;
	logic [2:0] index;
	logic       wr;

	assign index  = paddr[ADDR_W-1:3];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.separator_set <= SEP_RESET;
			cfg_q.delimiter_set <= DELIM_RESET;
			cfg_q.line_end_set  <= EOL_RESET;
			cfg_q.quote_set     <= QUOTE_RESET;
			cfg_q.keep_quotes   <= 1'b0;
		end else if (wr) begin
			unique case (index)
				REG_SEP:   cfg_q.separator_set <= pwdata;
				REG_DELIM: cfg_q.delimiter_set <= pwdata;
				REG_EOL:   cfg_q.line_end_set  <= pwdata;
				REG_QUOTE: cfg_q.quote_set     <= pwdata;
				REG_KEEP:  cfg_q.keep_quotes   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read data.
	always_comb begin
		unique case (index)
			REG_SEP:   prdata = cfg_q.separator_set;
			REG_DELIM: prdata = cfg_q.delimiter_set;
			REG_EOL:   prdata = cfg_q.line_end_set;
			REG_QUOTE: prdata = cfg_q.quote_set;
			REG_KEEP:  prdata = {{(DATA_W-1){1'b0}}, cfg_q.keep_quotes};
			default:   prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/lft_front.sv]
// Front part of the tokenizer: accepts one text word per cycle while the queue is not full, classifies the byte,
// updates the field state and writes the word's results as one queue entry.
// Depends on lft_pkg.
`default_nettype none

module lft_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lft_pkg::item_t item,
	input  wire logic           push,
	input  wire lft_pkg::cfg_t  cfg,
	input  wire logic           q_full,
	output logic                q_push,
	output lft_pkg::entry_t     q_data
);
	import lft_pkg::*;

	typedef enum logic [1:0] {
		LEAD_NONE,
		LEAD_SEP,
		LEAD_DELIM
	} lead_t;

	typedef struct packed {
		logic        in_field;
		lead_t       lead;
		logic [2:0]  quote_count;
		logic        escape;
		logic        cr;
		logic [15:0] line_count;
		logic        finished;
		logic        nonempty;
	} state_t;

	state_t      st_q;
	state_t      nxt;
	logic        accept;
	logic [7:0]  c;
	logic        is_delim;
	logic        is_eol;
	logic        is_sep;
	logic        is_quote;
	logic        even;
	logic        do_eol;
	logic [1:0]  n_v;
	logic [2:0]  qc_inc;
	result_t     rec_v [2];

	assign accept   = push && !q_full;
	assign c        = item.text_byte;
	assign is_delim = is_member(cfg.delimiter_set, c);
	assign is_eol   = is_member(cfg.line_end_set, c);
	assign is_sep   = is_member(cfg.separator_set, c);
	assign is_quote = is_member(cfg.quote_set, c);
	assign even     = !st_q.quote_count[0];
	assign qc_inc   = (st_q.quote_count == 3'd5) ? 3'd0 : st_q.quote_count + 3'd1;

	// Next state and the results of the current word.
	always_comb begin
		nxt      = st_q;
		n_v      = 2'd0;
		do_eol   = 1'b0;
		rec_v[0] = '0;
		rec_v[1] = '0;
		if (accept && !st_q.finished) begin
			if (item.input_end) begin
				if (st_q.in_field && st_q.nonempty) begin
					rec_v[n_v[0]] = make_result(KIND_FIELD_END, 8'd0, st_q.line_count);
					n_v = n_v + 2'd1;
				end
				rec_v[n_v[0]] = make_result(KIND_INPUT_END, 8'd0, st_q.line_count);
				n_v = n_v + 2'd1;
				nxt.in_field    = 1'b0;
				nxt.quote_count = 3'd0;
				nxt.nonempty    = 1'b0;
				nxt.escape      = 1'b0;
				nxt.lead        = LEAD_NONE;
				nxt.cr          = 1'b0;
				nxt.finished    = 1'b1;
			end else if (st_q.cr && c == CHAR_LF) begin
				// LF right after a line-ending CR is swallowed.
				nxt.cr = 1'b0;
			end else begin
				nxt.cr = 1'b0;
				if (st_q.escape) begin
					// Escaped byte is taken literally.
					nxt.escape = 1'b0;
					rec_v[n_v[0]] = make_result(KIND_BYTE, c, st_q.line_count);
					n_v = n_v + 2'd1;
					nxt.nonempty = 1'b1;
					if (!st_q.in_field) begin
						nxt.in_field    = 1'b1;
						nxt.lead        = LEAD_NONE;
						nxt.quote_count = 3'd0;
						if (c == CHAR_LF) begin
							nxt.line_count = st_q.line_count + 16'd1;
						end
					end
				end else if (!st_q.in_field) begin
					// Between fields: delimiter beats end of line beats separator.
					if (is_delim) begin
						if (st_q.lead != LEAD_SEP) begin
							rec_v[n_v[0]] = make_result(KIND_FIELD_END, 8'd0,
								st_q.line_count);
							n_v = n_v + 2'd1;
						end
						nxt.lead = LEAD_DELIM;
					end else if (c == CHAR_NUL || is_eol) begin
						do_eol = 1'b1;
					end else if (is_sep) begin
						if (st_q.lead == LEAD_NONE) begin
							nxt.lead = LEAD_SEP;
						end
					end else if (is_quote) begin
						nxt.in_field    = 1'b1;
						nxt.lead        = LEAD_NONE;
						nxt.quote_count = 3'd1;
						if (cfg.keep_quotes) begin
							rec_v[n_v[0]] = make_result(KIND_BYTE, c, st_q.line_count);
							n_v = n_v + 2'd1;
							nxt.nonempty = 1'b1;
						end
					end else if (c == CHAR_BSLASH) begin
						nxt.escape = 1'b1;
					end else begin
						nxt.in_field    = 1'b1;
						nxt.lead        = LEAD_NONE;
						nxt.quote_count = 3'd0;
						rec_v[n_v[0]] = make_result(KIND_BYTE, c, st_q.line_count);
						n_v = n_v + 2'd1;
						nxt.nonempty = 1'b1;
					end
				end else begin
					// Inside a field: ends only outside quotes, except on NUL.
					if (c == CHAR_NUL || (even && is_eol)) begin
						do_eol = 1'b1;
					end else if (even && (is_delim || is_sep)) begin
						rec_v[n_v[0]] = make_result(KIND_FIELD_END, 8'd0, st_q.line_count);
						n_v = n_v + 2'd1;
						nxt.in_field    = 1'b0;
						nxt.quote_count = 3'd0;
						nxt.nonempty    = 1'b0;
						nxt.escape      = 1'b0;
						nxt.lead        = is_delim ? LEAD_DELIM : LEAD_SEP;
					end else if (is_quote) begin
						nxt.quote_count = qc_inc;
						if (cfg.keep_quotes) begin
							rec_v[n_v[0]] = make_result(KIND_BYTE, c, st_q.line_count);
							n_v = n_v + 2'd1;
							nxt.nonempty = 1'b1;
						end else if (qc_inc == 3'd0 || qc_inc == 3'd3) begin
							// Every third quote yields one double quote.
							rec_v[n_v[0]] = make_result(KIND_BYTE, CHAR_DQUOTE,
								st_q.line_count);
							n_v = n_v + 2'd1;
							nxt.nonempty = 1'b1;
						end
					end else if (c == CHAR_BSLASH) begin
						nxt.escape = 1'b1;
					end else begin
						rec_v[n_v[0]] = make_result(KIND_BYTE, c, st_q.line_count);
						n_v = n_v + 2'd1;
						nxt.nonempty = 1'b1;
					end
				end
				// Line end closes any open field and counts the line.
				if (do_eol) begin
					if (st_q.in_field && st_q.nonempty) begin
						rec_v[n_v[0]] = make_result(KIND_FIELD_END, 8'd0, st_q.line_count);
						n_v = n_v + 2'd1;
					end
					rec_v[n_v[0]] = make_result(KIND_LINE_END, 8'd0,
						st_q.line_count + 16'd1);
					n_v = n_v + 2'd1;
					nxt.in_field    = 1'b0;
					nxt.quote_count = 3'd0;
					nxt.nonempty    = 1'b0;
					nxt.escape      = 1'b0;
					nxt.line_count  = st_q.line_count + 16'd1;
					nxt.lead        = LEAD_NONE;
					nxt.cr          = (c == CHAR_CR);
				end
			end
		end
		// Mark the final result of the word.
		if (n_v == 2'd1) begin
			rec_v[0].last_result = 1'b1;
		end else if (n_v == 2'd2) begin
			rec_v[1].last_result = 1'b1;
		end
	end

	assign q_push      = (n_v != 2'd0);
	assign q_data.two  = (n_v == 2'd2);
	assign q_data.rec0 = rec_v[0];
	assign q_data.rec1 = rec_v[1];

	// Field state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else begin
			st_q <= nxt;
		end
	end

	// After input end nothing more is queued.
	a_no_push_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.finished |-> !q_push)
		else $error("entry queued after input end");

	// Exactly the final record of an entry carries the last mark.
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_data.two ? (q_data.rec1.last_result && !q_data.rec0.last_result)
			: q_data.rec0.last_result))
		else $error("last mark misplaced in queue entry");

	// A word is never queued while the queue is full.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("entry queued into a full queue");

endmodule

`default_nettype wire

[hw/rtl/lft_queue.sv]
// Short queue of result entries between the front and back parts.
// Depends on lft_pkg.
`default_nettype none

module lft_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  wire lft_pkg::entry_t wdata,
	output logic                 full,
	input  wire logic            rd,
	output lft_pkg::entry_t      rdata,
	output logic                 empty
);
	import lft_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);

	entry_t           mem [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == (PTR_W+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (PTR_W+1)'(do_wr) - (PTR_W+1)'(do_rd);
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lft_back.sv]
// Back part of the tokenizer: takes queue entries and hands out their results
// one result at a time from an output register. Depends on lft_pkg.
`default_nettype none

module lft_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lft_pkg::entry_t q_data,
	input  wire logic            q_empty,
	output logic                 q_pop,
	output lft_pkg::result_t     result,
	output logic                 empty,
	input  wire logic            pop
);
	import lft_pkg::*;

	entry_t ent_q;
	logic   valid_q;
	logic   sel_q;
	logic   taken;
	logic   advance;

	assign taken   = pop && valid_q;
	assign advance = !valid_q || (taken && (sel_q || !ent_q.two));
	assign q_pop   = advance && !q_empty;
	assign empty   = !valid_q;
	assign result  = sel_q ? ent_q.rec1 : ent_q.rec0;

	// Output entry register and record select.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (advance) begin
			valid_q <= !q_empty;
			sel_q   <= 1'b0;
		end else if (taken) begin
			sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ent_q <= q_data;
		end
	end

	// The second record is only shown for a two-record entry.
	a_sel_two: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (valid_q && ent_q.two))
		else $error("second record selected on a single-record entry");

	// Taking the first of two records moves on to the second.
	a_step_second: assert property (@(posedge clk) disable iff (!arst_n)
		(taken && !sel_q && ent_q.two) |=> (valid_q && sel_q))
		else $error("second record lost");

	// Taking a final record with work queued leaves a fresh entry in place.
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(taken && result.last_result && !q_empty) |=> (valid_q && !sel_q))
		else $error("queued entry not loaded");

endmodule

`default_nettype wire

[hw/rtl/line_field_tokenizer_unit.sv]
// Line field tokenizer: splits a byte stream into field bytes and field, line
// and input end markers. One text word is taken per cycle while the result
// queue has room; a taken word's results pass through the queue and then the
// output register. Results leave at one per cycle while the receiver pops.
// Reset clears the field state, the line count and the queue, and loads the
// default character sets.
`default_nettype none

module line_field_tokenizer_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [lft_pkg::ADDR_W-1:0] paddr,
	input  wire logic [lft_pkg::DATA_W-1:0] pwdata,
	output logic      [lft_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	input  wire lft_pkg::item_t             item,
	input  wire logic                       push,
	output logic                            full,
	output lft_pkg::result_t                result,
	output logic                            empty,
	input  wire logic                       pop
);
	import lft_pkg::*;

	cfg_t   cfg;
	entry_t wr_entry;
	entry_t rd_entry;
	logic   q_push;
	logic   q_full;
	logic   q_pop;
	logic   q_empty;

	assign full = q_full;

	lft_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lft_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.push   (push),
		.cfg    (cfg),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (wr_entry)
	);

	lft_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (wr_entry),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (rd_entry),
		.empty  (q_empty)
	);

	lft_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (rd_entry),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

`default_nettype wire

[sim/line_field_tokenizer_unit_test.sv]
// Self-checking testbench for the line field tokenizer unit: drives text words and
// register writes, predicts every token in step with the block and checks them in order.
// Depends on lft_pkg and line_field_tokenizer_unit.

module line_field_tokenizer_unit_test;
	import lft_pkg::*;

	typedef enum logic [1:0] {
		LEAD_NONE,
		LEAD_SEP,
		LEAD_DELIM
	} lead_t;

	typedef enum int {
		REG_SEPARATOR,
		REG_DELIMITER,
		REG_LINE_END,
		REG_QUOTE,
		REG_KEEP_QUOTES
	} reg_index_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	item_t               word_in = '0;
	logic                push = 1'b0;
	logic                full;
	result_t             token;
	logic                empty;
	logic                pop = 1'b0;

	// Idle chances in percent, and a receiver hold-off counted in cycles.
	int                  tx_idle_pct = 0;
	int                  rx_idle_pct = 0;
	int                  hold_left = 0;
	int                  mismatches = 0;

	// Predicted register contents.
	logic [63:0]         cfg_sep = SEP_RESET;
	logic [63:0]         cfg_delim = DELIM_RESET;
	logic [63:0]         cfg_eol = EOL_RESET;
	logic [63:0]         cfg_quote = QUOTE_RESET;
	logic                cfg_keep = 1'b0;

	// Predicted tokenizer state.
	logic                tok_in_field = 1'b0;
	lead_t               tok_lead = LEAD_NONE;
	logic [2:0]          tok_quotes = '0;
	logic                tok_escape = 1'b0;
	logic                tok_cr = 1'b0;
	logic [15:0]         tok_lines = '0;
	logic                tok_done = 1'b0;
	logic                tok_has_byte = 1'b0;

	result_t             step_tokens[$];
	result_t             expected_tokens[$];
	result_t             want_token;

	line_field_tokenizer_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (word_in),
		.push    (push),
		.full    (full),
		.result  (token),
		.empty   (empty),
		.pop     (pop)
	);

	// Clock with a period of 20.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// A byte matches a set when it is nonzero and equals one of its eight lanes.
	function automatic logic hits(logic [63:0] set, logic [7:0] c);
		if (c == CHAR_NUL) begin
			return 1'b0;
		end
		for (int i = 0; i < SET_BYTES; i++) begin
			if (set[8*i +: 8] == c) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void note(kind_t k, logic [7:0] b);
		result_t r;
		r.kind        = k;
		r.field_byte  = b;
		r.line_number = tok_lines;
		r.last_result = 1'b0;
		step_tokens = {step_tokens, r};
	endfunction

	function automatic void emit(logic [7:0] c);
		note(KIND_BYTE, c);
		tok_has_byte = 1'b1;
	endfunction

	function automatic void close_field();
		tok_in_field = 1'b0;
		tok_quotes   = '0;
		tok_has_byte = 1'b0;
		tok_escape   = 1'b0;
	endfunction

	function automatic void end_line(logic [7:0] c);
		if (tok_in_field && tok_has_byte) begin
			note(KIND_FIELD_END, 8'h00);
		end
		close_field();
		tok_lines = tok_lines + 16'd1;
		note(KIND_LINE_END, 8'h00);
		tok_lead = LEAD_NONE;
		tok_cr   = (c == CHAR_CR);
	endfunction

	// Works out the tokens caused by one accepted word and queues them.
	function automatic void tokenize(item_t w);
		logic [7:0] c;
		logic       even;
		logic       dl;
		step_tokens.delete();
		if (tok_done) begin
			return;
		end
		c = w.text_byte;
		if (w.input_end) begin
			if (tok_in_field && tok_has_byte) begin
				note(KIND_FIELD_END, 8'h00);
			end
			close_field();
			tok_lead = LEAD_NONE;
			tok_cr   = 1'b0;
			note(KIND_INPUT_END, 8'h00);
			tok_done = 1'b1;
		end else begin
			// A line feed right after a CR line end is swallowed.
			if (tok_cr) begin
				tok_cr = 1'b0;
				if (c == CHAR_LF) begin
					return;
				end
			end
			if (tok_escape) begin
				tok_escape = 1'b0;
				emit(c);
				if (!tok_in_field) begin
					tok_in_field = 1'b1;
					tok_lead     = LEAD_NONE;
					tok_quotes   = '0;
					if (c == CHAR_LF) begin
						tok_lines = tok_lines + 16'd1;
					end
				end
			end else if (!tok_in_field) begin
				// Between fields: delimiter first, then line end, then separator.
				if (hits(cfg_delim, c)) begin
					if (tok_lead != LEAD_SEP) begin
						note(KIND_FIELD_END, 8'h00);
					end
					tok_lead = LEAD_DELIM;
				end else if (c == CHAR_NUL || hits(cfg_eol, c)) begin
					end_line(c);
				end else if (hits(cfg_sep, c)) begin
					if (tok_lead == LEAD_NONE) begin
						tok_lead = LEAD_SEP;
					end
				end else if (hits(cfg_quote, c)) begin
					tok_in_field = 1'b1;
					tok_lead     = LEAD_NONE;
					tok_quotes   = 3'd1;
					if (cfg_keep) begin
						emit(c);
					end
				end else if (c == CHAR_BSLASH) begin
					tok_escape = 1'b1;
				end else begin
					tok_in_field = 1'b1;
					tok_lead     = LEAD_NONE;
					tok_quotes   = '0;
					emit(c);
				end
			end else begin
				// Inside a field: ends only outside quotes, except on NUL, and line end wins.
				even = !tok_quotes[0];
				dl   = hits(cfg_delim, c);
				if (c == CHAR_NUL || (even && hits(cfg_eol, c))) begin
					end_line(c);
				end else if (even && (dl || hits(cfg_sep, c))) begin
					note(KIND_FIELD_END, 8'h00);
					close_field();
					tok_lead = dl ? LEAD_DELIM : LEAD_SEP;
				end else if (hits(cfg_quote, c)) begin
					tok_quotes = 3'((int'(tok_quotes) + 1) % 6);
					if (cfg_keep) begin
						emit(c);
					end else if (tok_quotes % 3 == 0) begin
						emit(CHAR_DQUOTE);
					end
				end else if (c == CHAR_BSLASH) begin
					tok_escape = 1'b1;
				end else begin
					emit(c);
				end
			end
		end
		if (step_tokens.size() > 0) begin
			step_tokens[step_tokens.size() - 1].last_result = 1'b1;
		end
		foreach (step_tokens[i]) begin
			expected_tokens = {expected_tokens, step_tokens[i]};
		end
	endfunction

	// Receiver: pops at random, or holds off while a stall is requested.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			pop <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			pop <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Compare each popped token with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected token: kind %0d byte %02h line %0d",
					token.kind, token.field_byte, token.line_number);
				mismatches++;
			end else begin
				want_token = expected_tokens.pop_front();
				if (token.kind !== want_token.kind) begin
					$error("kind: expected %0d, got %0d", want_token.kind, token.kind);
					mismatches++;
				end
				if (token.field_byte !== want_token.field_byte) begin
					$error("field_byte: expected %02h, got %02h",
						want_token.field_byte, token.field_byte);
					mismatches++;
				end
				if (token.line_number !== want_token.line_number) begin
					$error("line_number: expected %0d, got %0d",
						want_token.line_number, token.line_number);
					mismatches++;
				end
				if (token.last_result !== want_token.last_result) begin
					$error("last_result: expected %0b, got %0b",
						want_token.last_result, token.last_result);
					mismatches++;
				end
			end
		end
	end

	// Offers one word, with random gaps, and predicts it once it is taken.
	task automatic send_word(input item_t w);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push    <= 1'b1;
		word_in <= w;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		tokenize(w);
	endtask

	task automatic send_byte(input logic [7:0] b);
		item_t w;
		w.text_byte = b;
		w.input_end = 1'b0;
		send_word(w);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i]);
		end
	endtask

	// Stops sending and waits until every predicted token has come out.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (expected_tokens.size() != 0) begin
			@(posedge clk);
		end
		// Words without tokens may still be in the pipeline.
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(8 * int'(idx));
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		case (idx)
			REG_SEPARATOR: begin
				cfg_sep = value;
			end
			REG_DELIMITER: begin
				cfg_delim = value;
			end
			REG_LINE_END: begin
				cfg_eol = value;
			end
			REG_QUOTE: begin
				cfg_quote = value;
			end
			REG_KEEP_QUOTES: begin
				cfg_keep = value[0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_sets(input logic [63:0] sep, input logic [63:0] delim,
		input logic [63:0] eol, input logic [63:0] quote, input logic [63:0] keep);
		drain();
		write_reg(REG_SEPARATOR, sep);
		write_reg(REG_DELIMITER, delim);
		write_reg(REG_LINE_END, eol);
		write_reg(REG_QUOTE, quote);
		write_reg(REG_KEEP_QUOTES, keep);
	endtask

	// Punctuation and control bytes that make the sets interesting.
	function automatic logic [7:0] pick_special();
		case ($urandom_range(9))
			0: return " ";
			1: return 8'h09;
			2: return ",";
			3: return ";";
			4: return CHAR_DQUOTE;
			5: return "'";
			6: return CHAR_LF;
			7: return CHAR_CR;
			8: return "|";
			default: return CHAR_BSLASH;
		endcase
	endfunction

	// Text bytes weighted toward the bytes that the current sets react to.
	function automatic logic [7:0] pick_text();
		int r;
		int lane;
		r    = $urandom_range(99);
		lane = $urandom_range(SET_BYTES - 1);
		if (r < 14) begin
			return cfg_sep[8*lane +: 8];
		end else if (r < 24) begin
			return cfg_delim[8*lane +: 8];
		end else if (r < 31) begin
			return cfg_eol[8*lane +: 8];
		end else if (r < 41) begin
			return cfg_quote[8*lane +: 8];
		end else if (r < 46) begin
			return CHAR_BSLASH;
		end else if (r < 49) begin
			return CHAR_CR;
		end else if (r < 52) begin
			return CHAR_LF;
		end else if (r < 54) begin
			return CHAR_NUL;
		end else if (r < 84) begin
			return 8'($urandom_range(8'h7A, 8'h61));
		end
		return 8'($urandom_range(255));
	endfunction

	task automatic load_setting(input int which);
		logic [63:0] sets [4];
		case (which)
			0, 4: begin
				apply_sets(64'h0920, 64'h3B2C, 64'h0D0A, 64'h2722, 64'($urandom_range(1)));
			end
			1: begin
				apply_sets('0, '0, '0, '0, '0);
			end
			3: begin
				apply_sets('1, '1, '1, '1, '1);
			end
			default: begin
				for (int s = 0; s < 4; s++) begin
					for (int i = 0; i < SET_BYTES; i++) begin
						case ($urandom_range(9))
							0, 1, 2, 3: sets[s][8*i +: 8] = 8'h00;
							4, 5, 6, 7: sets[s][8*i +: 8] = pick_special();
							default: sets[s][8*i +: 8] = 8'($urandom_range(255));
						endcase
					end
				end
				apply_sets(sets[0], sets[1], sets[2], sets[3], {$urandom, $urandom});
			end
		endcase
	endtask

	// Reset sets: escaped newline at field start, CR swallowing LF, NUL as line end.
	task automatic test_defaults();
		send_text("a");
		send_byte(8'hFF);
		send_text(" \\\nb\015\nc\015");
		send_byte(CHAR_NUL);
	endtask

	// Empty fields, separators before a delimiter, quoted delimiters, quote runs.
	task automatic test_quotes_and_delimiters();
		apply_sets(64'h20, 64'h2C, 64'h0A, 64'h22, 64'h0);
		send_text(",a ,\"x,\"\"\"\"\",y\n");
	endtask

	// A byte in several sets: priority differs between fields and at a field end.
	task automatic test_overlapping_sets();
		apply_sets(64'h202C, 64'h3B2C, 64'h0A3B, 64'h0, 64'h1);
		send_text(";b;,c,\n");
	endtask

	task automatic test_random(input int phase);
		for (int k = 0; k < 3; k++) begin
			load_setting(phase * 2 + k);
			repeat (140) send_byte(pick_text());
		end
	endtask

	// The receiver stops for a long stretch so that the block fills and stalls.
	task automatic test_backpressure();
		load_setting(0);
		@(posedge clk);
		hold_left = 200;
		repeat (60) send_byte(pick_text());
	endtask

	// Input end closes an open field and drops a pending escape; nothing follows.
	task automatic test_input_end();
		item_t w;
		apply_sets(64'h0920, 64'h2C, 64'h0D0A, 64'h22, 64'h0);
		send_text("ab\\");
		w.text_byte = 8'($urandom_range(255));
		w.input_end = 1'b1;
		send_word(w);
		repeat (6) begin
			w.text_byte = 8'($urandom_range(255));
			w.input_end = 1'($urandom_range(1));
			send_word(w);
		end
		drain();
		write_reg(REG_QUOTE, 64'h27);
		repeat (4) send_byte(pick_text());
	endtask

	initial begin
		tx_idle_pct = 6;
		rx_idle_pct = 76;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_defaults();
		test_quotes_and_delimiters();
		test_overlapping_sets();
		test_random(0);

		drain();
		tx_idle_pct = 76;
		rx_idle_pct = 6;
		test_random(1);

		drain();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_backpressure();
		test_random(2);
		test_input_end();

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS line_field_tokenizer_unit");
		end else begin
			$display("FAIL line_field_tokenizer_unit");
		end
		$finish;
	end

	// Upper bound on the whole run.
	initial begin
		#10_000_000;
		$display("FAIL line_field_tokenizer_unit");
		$finish;
	end

endmodule
